[design/calendar_date_counter_defines.svh]
// Assertion macros used by the calendar date counter.
`ifndef CALENDAR_DATE_COUNTER_DEFINES_SVH
`define CALENDAR_DATE_COUNTER_DEFINES_SVH

// Same-cycle implication, sampled on the block clock and off during reset.
`define CDC_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the block clock and off during reset.
`define CDC_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/cdc_pkg.sv]
// Types, constants and calendar functions of the calendar date counter.
package cdc_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD_CHK,
      ST_ADD,
      ST_ADD_LEAP,
      ST_WD_PREP,
      ST_WD_SUM,
      ST_WD_DIV7,
      ST_WD_MOD,
      ST_RESP
   } state_type;

   typedef enum logic {
      DIV_BY_100,
      DIV_BY_7
   } div_kind_type;

   typedef struct packed {
      div_kind_type kind;
      logic [13:0]  operand;
   } div_req_type;

   localparam logic [1:0] ERR_OK    = 2'd0;
   localparam logic [1:0] ERR_MONTH = 2'd1;
   localparam logic [1:0] ERR_DAY   = 2'd2;
   localparam logic [1:0] ERR_RANGE = 2'd3;

   localparam logic [13:0] MAX_YEAR   = 14'd9999;
   localparam logic [13:0] RESET_YEAR = 14'd2000;

   localparam logic [13:0] RECIP_100   = 14'd5243;
   localparam int          SHIFT_100   = 19;
   localparam logic [6:0]  DIVISOR_100 = 7'd100;
   localparam logic [13:0] RECIP_7     = 14'd9363;
   localparam int          SHIFT_7     = 16;
   localparam logic [6:0]  DIVISOR_7   = 7'd7;

   function automatic logic leap_of(logic [1:0] year_low, logic [1:0] quot_low,
                                    logic [6:0] rem100);
      if (rem100 != 7'd0) begin
         return year_low == 2'd0;
      end else begin
         return quot_low == 2'd0;
      end
   endfunction

   function automatic logic [4:0] month_len(logic [3:0] month, logic leap);
      unique case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                     return 5'd30;
         4'd2:                                        return leap ? 5'd29 : 5'd28;
         default:                                     return 5'd0;
      endcase
   endfunction

   // Month term of the weekday sum, with January and February as months 13 and 14.
   function automatic logic [3:0] zeller_month_term(logic [3:0] month_adj);
      unique case (month_adj)
         4'd3:           return 4'd2;
         4'd4, 4'd5:     return 4'd3;
         4'd6, 4'd7:     return 4'd4;
         4'd8:           return 4'd5;
         4'd9, 4'd10:    return 4'd6;
         4'd11, 4'd12:   return 4'd7;
         4'd13:          return 4'd8;
         4'd14:          return 4'd9;
         default:        return 4'd0;
      endcase
   endfunction

endpackage

[design/calendar_date_counter.sv]
// Top level of the calendar date counter: sequencer, date registers and stream ports.
// The block holds one Gregorian date, 2000-01-01 after reset, and handles one request
// at a time; req_tready is low from acceptance until the response has been taken.
// A load request passes the load check, then the weekday states (prep, sum, divide by 7,
// modulo) before its response. An add request walks its n days, with a leap year step
// for each new year entered, then passes the same weekday states; a walk that reaches
// 9999-12-31 with days left stops there with a range error. The date walk advances one
// day per cycle except at a new year, and the next request can be accepted in the cycle
// after the response is taken. The leap year test and the weekday both go through one
// shared divide-by-constant unit (a registered reciprocal multiply).
`include "calendar_date_counter_defines.svh"

module calendar_date_counter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // year_in[13:0], month_in[17:14], day_in[22:18],
                                   // day_count[32:23], zero fill
   input  logic [0:0]  req_tuser,  // action: 0 load, 1 add
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata   // year_out[13:0], month_out[17:14], day_out[22:18],
                                   // weekday[25:23], error[27:26], zero fill
);

   cdc_pkg::state_type   state_ff, state_in;
   logic [13:0]          year_in_ff, year_in_in;
   logic [3:0]           month_in_ff, month_in_in;
   logic [4:0]           day_in_ff, day_in_in;
   logic [9:0]           count_ff, count_in;
   logic [13:0]          cur_year_ff, cur_year_in;
   logic [3:0]           cur_month_ff, cur_month_in;
   logic [4:0]           cur_day_ff, cur_day_in;
   logic                 leap_ff, leap_in;
   logic [1:0]           err_ff, err_in;
   logic [2:0]           weekday_ff, weekday_in;
   logic [13:0]          wsum_ff, wsum_in;

   cdc_pkg::div_req_type div_req;
   logic [10:0]          div_quot;
   logic [6:0]           div_rem;

   logic [4:0]           cur_mlen;
   logic                 at_max;
   logic [13:0]          year_adj;
   logic [3:0]           month_adj;
   logic                 load_leap;
   logic [14:0]          wsum_full;

   cdc_div_unit u_div (
      .clock   (clock),
      .div_req (div_req),
      .quot    (div_quot),
      .rem     (div_rem)
   );

   assign cur_mlen  = cdc_pkg::month_len(cur_month_ff, leap_ff);
   assign at_max    = (cur_year_ff == cdc_pkg::MAX_YEAR) && (cur_month_ff == 4'd12) &&
                      (cur_day_ff == 5'd31);
   assign year_adj  = (cur_month_ff < 4'd3) ? cur_year_ff - 14'd1 : cur_year_ff;
   assign month_adj = (cur_month_ff < 4'd3) ? cur_month_ff + 4'd12 : cur_month_ff;
   assign load_leap = cdc_pkg::leap_of(year_in_ff[1:0], div_quot[1:0], div_rem);
   assign wsum_full = 15'(cur_day_ff) + 15'({month_adj, 1'b0}) +
                      15'(cdc_pkg::zeller_month_term(month_adj)) + 15'(year_adj) +
                      15'(year_adj >> 2) + 15'(div_quot >> 2) - 15'(div_quot);

   assign req_tready = (state_ff == cdc_pkg::ST_IDLE);
   assign rsp_tvalid = (state_ff == cdc_pkg::ST_RESP);
   assign rsp_tdata  = {4'd0, err_ff, weekday_ff, cur_day_ff, cur_month_ff, cur_year_ff};

   always_comb begin
      div_req.kind    = cdc_pkg::DIV_BY_100;
      div_req.operand = year_adj;
      unique case (state_ff)
         cdc_pkg::ST_IDLE:    div_req.operand = req_tdata[13:0];
         cdc_pkg::ST_ADD:     div_req.operand = cur_year_ff + 14'd1;
         cdc_pkg::ST_WD_DIV7: begin
            div_req.kind    = cdc_pkg::DIV_BY_7;
            div_req.operand = wsum_ff;
         end
         default:             div_req.operand = year_adj;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      year_in_in   = year_in_ff;
      month_in_in  = month_in_ff;
      day_in_in    = day_in_ff;
      count_in     = count_ff;
      cur_year_in  = cur_year_ff;
      cur_month_in = cur_month_ff;
      cur_day_in   = cur_day_ff;
      leap_in      = leap_ff;
      err_in       = err_ff;
      weekday_in   = weekday_ff;
      wsum_in      = wsum_ff;
      unique case (state_ff)
         cdc_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               year_in_in  = req_tdata[13:0];
               month_in_in = req_tdata[17:14];
               day_in_in   = req_tdata[22:18];
               count_in    = req_tdata[32:23];
               err_in      = cdc_pkg::ERR_OK;
               state_in    = req_tuser[0] ? cdc_pkg::ST_ADD : cdc_pkg::ST_LOAD_CHK;
            end
         end
         cdc_pkg::ST_LOAD_CHK: begin
            priority if ((year_in_ff == 14'd0) || (year_in_ff > cdc_pkg::MAX_YEAR)) begin
               err_in = cdc_pkg::ERR_RANGE;
            end else if ((month_in_ff == 4'd0) || (month_in_ff > 4'd12)) begin
               err_in = cdc_pkg::ERR_MONTH;
            end else if ((day_in_ff == 5'd0) ||
                         (day_in_ff > cdc_pkg::month_len(month_in_ff, load_leap))) begin
               err_in = cdc_pkg::ERR_DAY;
            end else begin
               cur_year_in  = year_in_ff;
               cur_month_in = month_in_ff;
               cur_day_in   = day_in_ff;
               leap_in      = load_leap;
            end
            state_in = cdc_pkg::ST_WD_PREP;
         end
         cdc_pkg::ST_ADD: begin
            priority if (count_ff == 10'd0) begin
               state_in = cdc_pkg::ST_WD_PREP;
            end else if (at_max) begin
               err_in   = cdc_pkg::ERR_RANGE;
               state_in = cdc_pkg::ST_WD_PREP;
            end else begin
               count_in = count_ff - 10'd1;
               if (cur_day_ff < cur_mlen) begin
                  cur_day_in = cur_day_ff + 5'd1;
               end else begin
                  cur_day_in = 5'd1;
                  if (cur_month_ff < 4'd12) begin
                     cur_month_in = cur_month_ff + 4'd1;
                  end else begin
                     cur_month_in = 4'd1;
                     cur_year_in  = cur_year_ff + 14'd1;
                     state_in     = cdc_pkg::ST_ADD_LEAP;
                  end
               end
            end
         end
         cdc_pkg::ST_ADD_LEAP: begin
            leap_in  = cdc_pkg::leap_of(cur_year_ff[1:0], div_quot[1:0], div_rem);
            state_in = cdc_pkg::ST_ADD;
         end
         cdc_pkg::ST_WD_PREP: begin
            state_in = cdc_pkg::ST_WD_SUM;
         end
         cdc_pkg::ST_WD_SUM: begin
            wsum_in  = wsum_full[13:0];
            state_in = cdc_pkg::ST_WD_DIV7;
         end
         cdc_pkg::ST_WD_DIV7: begin
            state_in = cdc_pkg::ST_WD_MOD;
         end
         cdc_pkg::ST_WD_MOD: begin
            weekday_in = (div_rem[2:0] == 3'd6) ? 3'd0 : div_rem[2:0] + 3'd1;
            state_in   = cdc_pkg::ST_RESP;
         end
         cdc_pkg::ST_RESP: begin
            if (rsp_tready) begin
               state_in = cdc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cdc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cdc_pkg::ST_IDLE;
         cur_year_ff  <= cdc_pkg::RESET_YEAR;
         cur_month_ff <= 4'd1;
         cur_day_ff   <= 5'd1;
         leap_ff      <= 1'b1;
      end else begin
         state_ff     <= state_in;
         cur_year_ff  <= cur_year_in;
         cur_month_ff <= cur_month_in;
         cur_day_ff   <= cur_day_in;
         leap_ff      <= leap_in;
      end
   end

   always_ff @(posedge clock) begin
      year_in_ff  <= year_in_in;
      month_in_ff <= month_in_in;
      day_in_ff   <= day_in_in;
      count_ff    <= count_in;
      err_ff      <= err_in;
      weekday_ff  <= weekday_in;
      wsum_ff     <= wsum_in;
   end

   `CDC_ASSERT_IMP(a_busy_during_rsp, rsp_tvalid, !req_tready,
                   "request taken while a response waits")
   `CDC_ASSERT_NXT(a_busy_after_accept, req_tvalid && req_tready,
                   !req_tready && !rsp_tvalid, "no work cycle after an accepted request")
   `CDC_ASSERT_IMP(a_date_in_range, 1'b1,
                   (cur_month_ff >= 4'd1) && (cur_month_ff <= 4'd12) &&
                   (cur_day_ff >= 5'd1) && (cur_day_ff <= cur_mlen) &&
                   (cur_year_ff >= 14'd1) && (cur_year_ff <= cdc_pkg::MAX_YEAR),
                   "current date is not a valid calendar date")
   `CDC_ASSERT_NXT(a_walk_counts_down,
                   (state_ff == cdc_pkg::ST_ADD) && (count_ff != 10'd0) && !at_max,
                   count_ff == $past(count_ff) - 10'd1, "day walk did not consume one day")

endmodule

[design/cdc_div_unit.sv]
// Shared constant divider: reciprocal multiply, registered, then quotient and remainder.
module cdc_div_unit (
   input  logic                   clock,
   input  cdc_pkg::div_req_type   div_req,
   output logic [10:0]            quot,
   output logic [6:0]             rem
);

   logic [13:0]           recip;
   logic [27:0]           prod_in;
   logic [27:0]           prod_ff;
   logic [13:0]           operand_ff;
   cdc_pkg::div_kind_type kind_ff;
   logic [6:0]            divisor;
   logic [17:0]           back_prod;

   always_comb begin
      unique case (div_req.kind)
         cdc_pkg::DIV_BY_100: recip = cdc_pkg::RECIP_100;
         cdc_pkg::DIV_BY_7:   recip = cdc_pkg::RECIP_7;
         default:             recip = cdc_pkg::RECIP_100;
      endcase
      prod_in = 28'(div_req.operand) * 28'(recip);
   end

   always_ff @(posedge clock) begin
      prod_ff    <= prod_in;
      operand_ff <= div_req.operand;
      kind_ff    <= div_req.kind;
   end

   always_comb begin
      unique case (kind_ff)
         cdc_pkg::DIV_BY_100: begin
            quot    = 11'(prod_ff >> cdc_pkg::SHIFT_100);
            divisor = cdc_pkg::DIVISOR_100;
         end
         cdc_pkg::DIV_BY_7: begin
            quot    = 11'(prod_ff >> cdc_pkg::SHIFT_7);
            divisor = cdc_pkg::DIVISOR_7;
         end
         default: begin
            quot    = 11'(prod_ff >> cdc_pkg::SHIFT_100);
            divisor = cdc_pkg::DIVISOR_100;
         end
      endcase
      back_prod = 18'(quot) * 18'(divisor);
      rem       = 7'(operand_ff - back_prod[13:0]);
   end

endmodule

[verif/calendar_date_counter_tb.sv]
// Testbench for the calendar date counter: directed and random requests against a predictor.
`timescale 1ns / 1ps

module calendar_date_counter_tb;

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_ADD  = 1'b1;
   localparam int   STALL_LIMIT = 8000;
   localparam int   HOLD_CYCLES = 300;
   localparam int   DRAIN_CYCLES = 16;

   typedef struct packed {
      logic [9:0]  count;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [13:0] year;
   } date_fields_type;

   typedef struct packed {
      logic [1:0]  err;
      logic [2:0]  wday;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [13:0] year;
   } date_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;

   date_result_type pending_dates[$];
   int unsigned  cal_year = 2000;
   int unsigned  cal_month = 1;
   int unsigned  cal_day = 1;
   int           mismatches = 0;
   int           quiet_cycles = 0;
   bit           send_gaps = 1'b1;
   bit           recv_gaps = 1'b1;
   bit           recv_hold = 1'b0;

   calendar_date_counter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   function automatic bit is_leap(int unsigned y);
      if (y % 400 == 0) return 1'b1;
      if (y % 100 == 0) return 1'b0;
      return y % 4 == 0;
   endfunction

   function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
      case (m)
         2:             return is_leap(y) ? 29 : 28;
         4, 6, 9, 11:   return 30;
         1, 3, 5, 7, 8, 10, 12: return 31;
         default:       return 0;
      endcase
   endfunction

   // Weekday by a month offset table, Sunday first; January and February belong
   // to the year before.
   function automatic logic [2:0] weekday_of(int unsigned y, int unsigned m, int unsigned d);
      int unsigned offset;
      int unsigned yy;
      case (m)
         1, 5:   offset = 0;
         2, 6:   offset = 3;
         3, 11:  offset = 2;
         4, 7:   offset = 5;
         8:      offset = 1;
         10:     offset = 6;
         default: offset = 4;
      endcase
      yy = (m < 3) ? y - 1 : y;
      return 3'((yy + yy / 4 - yy / 100 + yy / 400 + offset + d) % 7);
   endfunction

   function automatic date_result_type predict_date(logic action, date_fields_type f);
      date_result_type r;
      int unsigned  left;
      r.err = cdc_pkg::ERR_OK;
      if (action == ACT_LOAD) begin
         if (f.year == 0 || f.year > cdc_pkg::MAX_YEAR) begin
            r.err = cdc_pkg::ERR_RANGE;
         end else if (f.month == 0 || f.month > 12) begin
            r.err = cdc_pkg::ERR_MONTH;
         end else if (f.day == 0 || f.day > days_in_month(f.month, f.year)) begin
            r.err = cdc_pkg::ERR_DAY;
         end else begin
            cal_year = f.year;
            cal_month = f.month;
            cal_day = f.day;
         end
      end else begin
         left = f.count;
         while (left != 0 && r.err == cdc_pkg::ERR_OK) begin
            if (cal_year == cdc_pkg::MAX_YEAR && cal_month == 12 && cal_day == 31) begin
               r.err = cdc_pkg::ERR_RANGE;
            end else begin
               left--;
               cal_day++;
               if (cal_day > days_in_month(cal_month, cal_year)) begin
                  cal_day = 1;
                  cal_month++;
                  if (cal_month > 12) begin
                     cal_month = 1;
                     cal_year++;
                  end
               end
            end
         end
      end
      r.year = 14'(cal_year);
      r.month = 4'(cal_month);
      r.day = 5'(cal_day);
      r.wday = weekday_of(cal_year, cal_month, cal_day);
      return r;
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : check_results
      date_result_type seen;
      date_result_type wanted;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = rsp_tdata[27:0];
         if (pending_dates.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %h", $time, rsp_tdata);
            mismatches++;
         end else begin
            wanted = pending_dates.pop_front();
            check_field("year", wanted.year, seen.year);
            check_field("month", wanted.month, seen.month);
            check_field("day", wanted.day, seen.day);
            check_field("weekday", wanted.wday, seen.wday);
            check_field("error", wanted.err, seen.err);
         end
      end
   end

   always @(negedge clock) begin
      rsp_tready <= !recv_hold && (!recv_gaps || $urandom_range(99) >= 32);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_request(input logic action, input date_fields_type f);
      date_result_type predicted;
      @(negedge clock);
      if (send_gaps) begin
         while ($urandom_range(99) < 32) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
         end
      end
      req_tdata <= {7'b0, f};
      req_tuser <= action;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predicted = predict_date(action, f);
      pending_dates.push_back(predicted);
   endtask

   task automatic load_date(input int unsigned y, input int unsigned m, input int unsigned d);
      send_request(ACT_LOAD, {10'($urandom_range(1023)), 5'(d), 4'(m), 14'(y)});
   endtask

   task automatic add_days(input int unsigned n);
      send_request(ACT_ADD, {10'(n), 5'($urandom_range(31)), 4'($urandom_range(15)),
                             14'($urandom_range(16383))});
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_dates.size() != 0) @(posedge clock);
   endtask

   function automatic int unsigned pick_year();
      case ($urandom_range(9))
         0, 1:    return $urandom_range(9999, 9997);
         2:       return $urandom_range(20, 1);
         3:       return $urandom_range(99, 1) * 100;
         default: return $urandom_range(9999, 1);
      endcase
   endfunction

   task automatic load_random_date();
      int unsigned y;
      int unsigned m;
      int unsigned d;
      y = pick_year();
      m = $urandom_range(12, 1);
      d = ($urandom_range(99) < 30) ? days_in_month(m, y)
                                    : $urandom_range(days_in_month(m, y), 1);
      load_date(y, m, d);
   endtask

   task automatic add_random_days();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 65) add_days($urandom_range(31));
      else if (pick < 85) add_days($urandom_range(1023));
      else add_days($urandom_range(1023, 960));
   endtask

   task automatic test_reset_date();
      add_days(0);
      wait_drained();
   endtask

   task automatic test_load_checks();
      load_date(1, 1, 1);
      load_date(9999, 12, 31);
      load_date(0, 0, 0);
      load_date(10000, 1, 1);
      load_date(16383, 15, 31);
      load_date(2021, 0, 10);
      load_date(2021, 15, 0);
      load_date(2021, 4, 31);
      load_date(2021, 6, 0);
      load_date(2000, 2, 29);
      load_date(1900, 2, 29);
      load_date(2023, 2, 29);
      load_date(2024, 2, 29);
      wait_drained();
   endtask

   task automatic test_add_rollover();
      load_date(2023, 12, 31);
      add_days(1);
      load_date(1900, 2, 28);
      add_days(1);
      add_days(1023);
      load_date(9999, 12, 30);
      add_days(1);
      add_days(1);
      add_days(0);
      load_date(9999, 11, 1);
      add_days(1023);
      wait_drained();
   endtask

   task automatic test_random_sequences();
      int unsigned pick;
      int unsigned m;
      int unsigned y;
      for (int i = 0; i < 540; i++) begin
         send_gaps = i < 200 || i >= 360;
         recv_gaps = send_gaps;
         pick = $urandom_range(99);
         if (pick < 12) begin
            send_request(ACT_LOAD, date_fields_type'($urandom()));
         end else if (pick < 20) begin
            y = pick_year();
            m = $urandom_range(12, 1);
            if ($urandom_range(1)) load_date(y, ($urandom_range(1)) ? 0 : $urandom_range(15, 13), 1);
            else load_date(y, m, days_in_month(m, y) + 1);
         end else if (pick < 40) begin
            load_random_date();
         end else begin
            add_random_days();
         end
      end
      wait_drained();
      send_gaps = 1'b1;
      recv_gaps = 1'b1;
   endtask

   task automatic test_backpressure();
      fork
         begin
            recv_hold = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            recv_hold = 1'b0;
         end
         begin
            for (int i = 0; i < 6; i++) begin
               if (i % 2 == 0) load_random_date();
               else add_days($urandom_range(40));
            end
         end
      join
      wait_drained();
      for (int i = 0; i < 4; i++) begin
         add_random_days();
         wait_drained();
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_date();
      test_load_checks();
      test_add_rollover();
      test_random_sequences();
      test_backpressure();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+design
design/cdc_pkg.sv
design/cdc_div_unit.sv
design/calendar_date_counter.sv
verif/calendar_date_counter_tb.sv
